// ===== src/bdq_pkg.sv =====
// Package for the bounded deque with search: sizes, codes and item types.
package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_CONTAINS   = 3'd4;
	localparam logic [2:0] REQ_REMOVE     = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] data_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         entry_count;
		logic               is_empty;
	} rsp_t;

	typedef struct packed {
		logic               push_front;
		logic               push_back;
		logic               pop_front;
		logic               remove;
		logic signed [31:0] data_value;
		logic [CNT_W-1:0]   count;
	} cell_cmd_t;

endpackage

// ===== src/bdq_cell.sv =====
// One storage cell of the deque chain with its own match comparator.
module bdq_cell (
	input  logic                      clk,
	input  bdq_pkg::cell_cmd_t        cmd,
	input  logic [bdq_pkg::IDX_W-1:0] index,
	input  logic signed [31:0]        left_value,
	input  logic signed [31:0]        right_value,
	input  logic                      seen_in,
	output logic                      seen_out,
	output logic signed [31:0]        value,
	output logic signed [31:0]        value_d
);
	import bdq_pkg::*;

	logic signed [31:0] value_q;
	logic               active;
	logic               at_count;
	logic               match;

	assign active   = CNT_W'(index) < cmd.count;
	assign at_count = CNT_W'(index) == cmd.count;
	assign match    = active && (value_q == cmd.data_value);
	assign seen_out = seen_in | match;
	assign value    = value_q;

	always_comb begin
		value_d = value_q;
		if (cmd.push_front) begin
			value_d = (index == '0) ? cmd.data_value : left_value;
		end else if (cmd.push_back) begin
			if (at_count) begin
				value_d = cmd.data_value;
			end
		end else if (cmd.pop_front) begin
			value_d = right_value;
		end else if (cmd.remove) begin
			if (seen_out) begin
				value_d = right_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

// ===== src/bounded_deque_with_search_top.sv =====
// Top level of the bounded deque with search: cell chain, count and result register.
//
// Requests arrive on req (req_valid, req_stall) and each produces exactly one
// item on rsp (rsp_valid, rsp_stall). A request is pushed to the front or back,
// pops the front or back, tests membership, or removes the first matching value.
// Every stored value sits in its own cell; all cells compare against the request
// value at once and shift toward their neighbors in the same cycle, so one
// request is processed per cycle while rsp is not stalled.
// The result is registered: it appears on rsp the cycle after acceptance.
// Throughput is one item per cycle while rsp is not stalled.
// When the receiver stalls, the result register holds its item and req_stall
// rises until that item is taken; the cells do not change in that time.
// Reset clears the count and the result valid flag, so the deque starts empty.
module bounded_deque_with_search_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bdq_pkg::rsp_t rsp
);
	import bdq_pkg::*;

	logic               accept;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               full;
	logic               empty;
	logic               found;
	logic [1:0]         status;
	cell_cmd_t          cmd;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               rsp_d;
	logic signed [31:0] vals   [DEPTH];
	logic signed [31:0] vals_d [DEPTH];
	logic               seen   [DEPTH+1];
	logic [IDX_W-1:0]   back_idx;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign found     = seen[DEPTH];

	always_comb begin
		cmd.push_front = accept && (req.req_type == REQ_PUSH_FRONT) && !full;
		cmd.push_back  = accept && (req.req_type == REQ_PUSH_BACK) && !full;
		cmd.pop_front  = accept && (req.req_type == REQ_POP_FRONT) && !empty;
		cmd.remove     = accept && (req.req_type == REQ_REMOVE);
		cmd.data_value = req.data_value;
		cmd.count      = count_q;
	end

	assign seen[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_v;
		logic signed [31:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = req.data_value;
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end
		bdq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.index       (IDX_W'(i)),
			.left_value  (left_v),
			.right_value (right_v),
			.seen_in     (seen[i]),
			.seen_out    (seen[i+1]),
			.value       (vals[i]),
			.value_d     (vals_d[i])
		);
	end

	always_comb begin
		status  = ST_OK;
		count_d = count_q;
		case (req.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (found) begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign back_idx = IDX_W'(count_d - 1'b1);

	always_comb begin
		rsp_d.status      = status;
		rsp_d.found       = found &&
			((req.req_type == REQ_CONTAINS) || (req.req_type == REQ_REMOVE));
		rsp_d.entry_count = 5'(count_d);
		rsp_d.is_empty    = count_d == '0;
		if (count_d == '0) begin
			rsp_d.front_value = '0;
			rsp_d.back_value  = '0;
		end else begin
			rsp_d.front_value = vals_d[0];
			rsp_d.back_value  = vals_d[back_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sv/tb_bounded_deque_with_search_top.sv =====
// Self-checking testbench for the bounded deque with search, with its own deque predictor.
module tb_bounded_deque_with_search_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam logic [2:0] REQ_NOP_6 = 3'd6;
	localparam logic [2:0] REQ_NOP_7 = 3'd7;
	localparam int RANDOM_PHASES = 20;
	localparam int PHASE_ITEMS = 50;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_item;

	logic signed [31:0] deque_vals [DEPTH];
	int unsigned deque_count = 0;
	rsp_t expected_rsps [$];
	int error_count = 0;

	int burst_left = 0;
	int hold_request = 0;
	int hold_left = 0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	bounded_deque_with_search_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	function automatic int find_first(input logic signed [31:0] v);
		for (int i = 0; i < deque_count; i++) begin
			if (deque_vals[i] == v)
				return i;
		end
		return -1;
	endfunction

	function automatic rsp_t deque_apply(input req_t r);
		rsp_t res;
		int hit;
		res = '0;
		res.status = ST_OK;
		case (r.req_type)
			REQ_PUSH_FRONT: begin
				if (deque_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = deque_count; i > 0; i--)
						deque_vals[i] = deque_vals[i-1];
					deque_vals[0] = r.data_value;
					deque_count++;
				end
			end
			REQ_PUSH_BACK: begin
				if (deque_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					deque_vals[deque_count] = r.data_value;
					deque_count++;
				end
			end
			REQ_POP_FRONT: begin
				if (deque_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					for (int i = 0; i + 1 < deque_count; i++)
						deque_vals[i] = deque_vals[i+1];
					deque_count--;
				end
			end
			REQ_POP_BACK: begin
				if (deque_count == 0)
					res.status = ST_EMPTY;
				else
					deque_count--;
			end
			REQ_CONTAINS: begin
				res.found = (find_first(r.data_value) >= 0);
			end
			REQ_REMOVE: begin
				hit = find_first(r.data_value);
				if (hit >= 0) begin
					res.found = 1'b1;
					for (int i = hit; i + 1 < deque_count; i++)
						deque_vals[i] = deque_vals[i+1];
					deque_count--;
				end
			end
			default: ;
		endcase
		if (deque_count == 0) begin
			res.front_value = '0;
			res.back_value = '0;
		end else begin
			res.front_value = deque_vals[0];
			res.back_value = deque_vals[deque_count-1];
		end
		res.entry_count = deque_count[4:0];
		res.is_empty = (deque_count == 0);
		return res;
	endfunction

	always @(posedge clk) begin
		rsp_t exp;
		if (arst_n) begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("result item with no request outstanding");
				end else begin
					exp = expected_rsps.pop_front();
					if (rsp_item.status !== exp.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp_item.status, exp.status));
					if (rsp_item.found !== exp.found)
						report_mismatch($sformatf("found %0b, expected %0b",
							rsp_item.found, exp.found));
					if (rsp_item.front_value !== exp.front_value)
						report_mismatch($sformatf("front_value %0d, expected %0d",
							rsp_item.front_value, exp.front_value));
					if (rsp_item.back_value !== exp.back_value)
						report_mismatch($sformatf("back_value %0d, expected %0d",
							rsp_item.back_value, exp.back_value));
					if (rsp_item.entry_count !== exp.entry_count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							rsp_item.entry_count, exp.entry_count));
					if (rsp_item.is_empty !== exp.is_empty)
						report_mismatch($sformatf("is_empty %0b, expected %0b",
							rsp_item.is_empty, exp.is_empty));
				end
			end
			if (req_valid && req_stall === 1'b0)
				expected_rsps.push_back(deque_apply(req_item));
		end
	end

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 200);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			case (stall_mode)
				STALL_NONE:  rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
				default:     rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	function automatic req_t make_req(input logic [2:0] kind, input logic signed [31:0] v);
		req_t r;
		r.req_type = kind;
		r.data_value = v;
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return -32'sd1;
			3, 4:    return $urandom;
			default: return $urandom_range(0, 5);
		endcase
	endfunction

	function automatic req_t random_req(input int unsigned push_pct, input int unsigned pop_pct);
		int unsigned roll;
		logic [2:0] kind;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			kind = $urandom_range(0, 1) ? REQ_NOP_7 : REQ_NOP_6;
		else if (roll < 2 + push_pct)
			kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		else if (roll < 2 + push_pct + pop_pct)
			kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
		else
			kind = $urandom_range(0, 1) ? REQ_REMOVE : REQ_CONTAINS;
		return make_req(kind, pick_value());
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		req_item <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_requests();
		send_req(make_req(REQ_POP_FRONT, 32'sd7));
		send_req(make_req(REQ_POP_BACK, -32'sd7));
		send_req(make_req(REQ_CONTAINS, 32'sd0));
		send_req(make_req(REQ_REMOVE, 32'sd0));
		send_req(make_req(REQ_NOP_6, 32'sh7fff_ffff));
		send_req(make_req(REQ_NOP_7, 32'sh8000_0000));
		wait_idle();
	endtask

	task automatic test_fill_and_overflow();
		send_req(make_req(REQ_PUSH_FRONT, 32'sh8000_0000));
		send_req(make_req(REQ_PUSH_BACK, 32'sh7fff_ffff));
		send_req(make_req(REQ_PUSH_FRONT, -32'sd1));
		for (int i = 3; i < DEPTH - 1; i++)
			send_req(make_req(REQ_PUSH_BACK, i % 4));
		send_req(make_req(REQ_PUSH_BACK, 32'sh1234_5678));
		send_req(make_req(REQ_PUSH_FRONT, 32'sd11));
		send_req(make_req(REQ_PUSH_BACK, 32'sd12));
		// The search must reach the value in the last slot.
		send_req(make_req(REQ_CONTAINS, 32'sh1234_5678));
		// Only the first of the duplicate values may go.
		send_req(make_req(REQ_REMOVE, 32'sd2));
		send_req(make_req(REQ_CONTAINS, 32'sd2));
		send_req(make_req(REQ_REMOVE, 32'sd99));
		send_req(make_req(REQ_POP_FRONT, 32'sd0));
		send_req(make_req(REQ_POP_BACK, 32'sd0));
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		burst_left = 40;
		repeat (40)
			send_req(random_req(45, 25));
		wait_idle();
	endtask

	task automatic test_random_traffic();
		traffic_mix_t mix;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mix = traffic_mix_t'($urandom_range(0, 2));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case (mix)
					MIX_FILL:  send_req(random_req(65, 15));
					MIX_DRAIN: send_req(random_req(15, 65));
					default:   send_req(random_req(35, 35));
				endcase
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_requests();
		test_fill_and_overflow();
		test_backpressure();
		test_random_traffic();
		if (expected_rsps.size() != 0)
			report_mismatch("requests left without a result item");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
src/bdq_pkg.sv
src/bdq_cell.sv
src/bounded_deque_with_search_top.sv
tb/sv/tb_bounded_deque_with_search_top.sv
